/* hdl/bqm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bqm_pkg: shared types and constants for the biquad magnitude evaluator
// Widths of the fixed-point datapath, Taylor constants, register map and
// rounding helpers used by the top level and its cells.
// ----------------------------------------------------------------------------
package bqm_pkg;

    localparam int PHASE_BITS_DEF = 16;

    // cosine datapath (Q30)
    localparam int TAYLOR_TERMS = 7;
    localparam int X_W          = 31;   // quarter-wave angle, Q1.30
    localparam int X2_W         = 32;   // squared angle, Q30
    localparam int T_W          = 31;   // series value in [0, 1], Q30
    localparam int N2_W         = 31;   // scaled product ahead of the small divide
    localparam logic [T_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [32:0]    TWO_PI_Q30 = 33'd6746518852;

    // Horner divisors 182, 132, 90, 56, 30, 12, 2, each halved
    localparam int TAYLOR_HALF [TAYLOR_TERMS] = '{91, 66, 45, 28, 15, 6, 1};

    // coefficient datapath (Q48)
    localparam int COEF_W = 32;
    localparam int PROD_W = 64;
    localparam int Q48_W  = 56;
    localparam int K_W    = 58;
    localparam int UA_W   = 57;
    localparam int HI_W   = 58;
    localparam int LO_W   = 61;
    localparam int M_W    = 58;
    localparam int SUM_W  = 60;

    // divider and square root
    localparam int DIV_W   = 59;
    localparam int DIV_LOW = 16;
    localparam int QUO_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 34;
    localparam int MAG_W   = 32;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_COEF_0 = 3'd0,
        CFG_NUM_COEF_1 = 3'd1,
        CFG_NUM_COEF_2 = 3'd2,
        CFG_DEN_COEF_1 = 3'd3,
        CFG_DEN_COEF_2 = 3'd4
    } t_cfg_idx;

    localparam logic signed [COEF_W-1:0] NUM_COEF_0_RST = 32'sh1000_0000;

    // result classification carried alongside the divider and root cells
    typedef struct packed {
        logic sat;
        logic pole;
        logic zero;
    } t_res_flags;

    // Q56 product rounded to Q48, half away from zero
    function automatic logic signed [Q48_W-1:0] q48_round(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [Q48_W-1:0]  rnd;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        rnd = Q48_W'((mag + 64'd128) >> 8);
        return p[PROD_W-1] ? $signed(Q48_W'(0) - rnd) : $signed(rnd);
    endfunction

    // magnitude of a Q48 term
    function automatic logic [UA_W-1:0] k_mag(input logic signed [K_W-1:0] v);
        return v[K_W-1] ? UA_W'(-v) : UA_W'(v);
    endfunction

endpackage
`default_nettype wire

/* hdl/bqm_taylor_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bqm_taylor_cell: one Horner step of the cosine series
// Computes t' = 1 - round(x2 * t / d) in Q30 over three stages and clamps
// the result to [0, 1]. d is even, so the divide is a shift and a small
// reciprocal multiply with a one-step correction.
// ----------------------------------------------------------------------------
module bqm_taylor_cell #(
    parameter int HALF_DIV = 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [bqm_pkg::X2_W-1:0] i_x2,
    input  wire logic [bqm_pkg::T_W-1:0]  i_t,
    input  wire logic                     i_neg,
    output logic                          o_valid,
    output logic [bqm_pkg::X2_W-1:0]      o_x2,
    output logic [bqm_pkg::T_W-1:0]       o_t,
    output logic                          o_neg
);
    import bqm_pkg::*;

    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / HALF_DIV);
    localparam logic [63:0] RND   = 64'(HALF_DIV) << 30;

    logic [2:0]        r_valid;
    logic [N2_W-1:0]   r_a_n2;
    logic [N2_W-1:0]   r_b_n2;
    logic [N2_W-1:0]   r_b_q0;
    logic [X2_W-1:0]   r_a_x2;
    logic [X2_W-1:0]   r_b_x2;
    logic [X2_W-1:0]   r_c_x2;
    logic [2:0]        r_neg;
    logic [T_W-1:0]    r_t;

    logic [N2_W-1:0]   n_a_n2;
    logic [N2_W-1:0]   n_b_q0;
    logic [N2_W+7:0]   w_qd;
    logic [N2_W-1:0]   w_rem;
    logic [N2_W-1:0]   w_q;
    logic [T_W-1:0]    n_t;

    // scale the product down by 2^31 with the rounding offset folded in
    assign n_a_n2 = N2_W'((64'(i_x2) * 64'(i_t) + RND) >> 31);

    // estimate the quotient, low by at most one
    assign n_b_q0 = N2_W'((64'(r_a_n2) * 64'(RECIP)) >> 32);

    // correct the estimate, subtract from one and clamp
    always_comb begin
        w_qd  = (N2_W+8)'(r_b_q0) * (N2_W+8)'(HALF_DIV);
        w_rem = r_b_n2 - N2_W'(w_qd);
        w_q   = (w_rem >= N2_W'(HALF_DIV)) ? r_b_q0 + N2_W'(1) : r_b_q0;
        n_t   = (w_q > N2_W'(ONE_Q30)) ? '0 : T_W'(ONE_Q30 - T_W'(w_q));
    end

    // advance the valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // advance the payload
    always_ff @(posedge i_clk) begin
        r_a_n2 <= n_a_n2;
        r_a_x2 <= i_x2;
        r_b_n2 <= r_a_n2;
        r_b_q0 <= n_b_q0;
        r_b_x2 <= r_a_x2;
        r_c_x2 <= r_b_x2;
        r_t    <= n_t;
        r_neg  <= {r_neg[1:0], i_neg};
    end

    assign o_valid = r_valid[2];
    assign o_x2    = r_c_x2;
    assign o_t     = r_t;
    assign o_neg   = r_neg[2];

endmodule
`default_nettype wire

/* hdl/bqm_div_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bqm_div_cell: one restoring division step
// Brings down the next dividend bit, trial-subtracts the divisor and shifts
// one quotient bit into the partial quotient.
// ----------------------------------------------------------------------------
module bqm_div_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [bqm_pkg::DIV_W-1:0]    i_rem,
    input  wire logic [bqm_pkg::DIV_W-1:0]    i_den,
    input  wire logic [bqm_pkg::DIV_LOW-1:0]  i_bits,
    input  wire logic [bqm_pkg::QUO_W-1:0]    i_quo,
    input  wire bqm_pkg::t_res_flags          i_flags,
    output logic                              o_valid,
    output logic [bqm_pkg::DIV_W-1:0]         o_rem,
    output logic [bqm_pkg::DIV_W-1:0]         o_den,
    output logic [bqm_pkg::DIV_LOW-1:0]       o_bits,
    output logic [bqm_pkg::QUO_W-1:0]         o_quo,
    output bqm_pkg::t_res_flags               o_flags
);
    import bqm_pkg::*;

    logic               r_valid;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_den;
    logic [DIV_LOW-1:0] r_bits;
    logic [QUO_W-1:0]   r_quo;
    t_res_flags         r_flags;

    logic [DIV_W:0]     w_acc;
    logic               w_ge;

    // trial subtract against the shifted remainder
    assign w_acc = {i_rem, i_bits[DIV_LOW-1]};
    assign w_ge  = (w_acc >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= w_ge ? DIV_W'(w_acc - {1'b0, i_den}) : DIV_W'(w_acc);
        r_den   <= i_den;
        r_bits  <= i_bits << 1;
        r_quo   <= {i_quo[QUO_W-2:0], w_ge};
        r_flags <= i_flags;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_bits  = r_bits;
    assign o_quo   = r_quo;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

/* hdl/bqm_sqrt_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bqm_sqrt_cell: one digit step of the integer square root
// Brings down two radicand bits, tries 4*root + 1 and shifts one root bit in.
// ----------------------------------------------------------------------------
module bqm_sqrt_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [bqm_pkg::REM_W-1:0]   i_rem,
    input  wire logic [bqm_pkg::ROOT_W-1:0]  i_root,
    input  wire logic [bqm_pkg::QUO_W-1:0]   i_rad,
    input  wire bqm_pkg::t_res_flags         i_flags,
    output logic                             o_valid,
    output logic [bqm_pkg::REM_W-1:0]        o_rem,
    output logic [bqm_pkg::ROOT_W-1:0]       o_root,
    output logic [bqm_pkg::QUO_W-1:0]        o_rad,
    output bqm_pkg::t_res_flags              o_flags
);
    import bqm_pkg::*;

    logic                r_valid;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [QUO_W-1:0]    r_rad;
    t_res_flags          r_flags;

    logic [REM_W+1:0]    w_acc;
    logic [REM_W+1:0]    w_trial;
    logic                w_ge;

    assign w_acc   = {i_rem, i_rad[QUO_W-1 -: 2]};
    assign w_trial = (REM_W+2)'({i_root, 2'b01});
    assign w_ge    = (w_acc >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= w_ge ? REM_W'(w_acc - w_trial) : REM_W'(w_acc);
        r_root  <= {i_root[ROOT_W-2:0], w_ge};
        r_rad   <= i_rad << 2;
        r_flags <= i_flags;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

/* hdl/biquad_magnitude_at_frequency.sv */
`default_nettype none
// Pipeline: 3 + 3*7 + 5 + 64 + 32 + 1 = 126 register stages; o_valid marks each result,
// which is taken at the edge ending its o_valid cycle.
// Throughput: one frequency per cycle while busy is low; every stage is a register, the
// Horner cells are pipelined as well, then 64 divider cells and 32 root cells.
// Reset: synchronous, clears all valid marks and loads b0 = 1.0, others zero;
// busy is high during reset and the cycle after. Results cannot be stalled.
// ----------------------------------------------------------------------------
// biquad_magnitude_at_frequency: biquad magnitude response evaluator
// Forms cos(w), cos(2w), the numerator and denominator powers and returns
// sqrt(num/den) in unsigned Q8.24 with saturation and pole flags.
// ----------------------------------------------------------------------------
module biquad_magnitude_at_frequency #(
    parameter int PHASE_BITS = bqm_pkg::PHASE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [PHASE_BITS-1:0]           i_freq_phase,
    output logic                                 o_valid,
    output logic [bqm_pkg::MAG_W-1:0]            o_magnitude,
    output logic                                 o_saturated,
    output logic                                 o_pole_on_circle,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bqm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bqm_pkg::COEF_W-1:0]      i_cfg_data
);
    import bqm_pkg::*;

    localparam int P_W  = PHASE_BITS - 1;
    localparam int XP_W = P_W + 33;
    localparam int LATENCY = 3 + 3 * TAYLOR_TERMS + 5 + QUO_W + ROOT_W + 1;
    localparam logic [PHASE_BITS-1:0] HALF    = PHASE_BITS'(1) << (PHASE_BITS - 1);
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic signed [K_W-1:0] ONE_Q48 = K_W'(64'h0001_0000_0000_0000);

    // ---------------------------------------------------------------- control
    logic r_run;
    logic w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy        = ~r_run;
    assign o_cfg_ready = r_run;
    assign w_accept    = start & ~busy;

    // ------------------------------------------------------ coefficient file
    logic signed [COEF_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= NUM_COEF_0_RST;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NUM_COEF_0: r_b0 <= $signed(i_cfg_data);
                CFG_NUM_COEF_1: r_b1 <= $signed(i_cfg_data);
                CFG_NUM_COEF_2: r_b2 <= $signed(i_cfg_data);
                CFG_DEN_COEF_1: r_a1 <= $signed(i_cfg_data);
                CFG_DEN_COEF_2: r_a2 <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // -------------------------------------- coefficient terms, recomputed each cycle
    logic signed [PROD_W-1:0] r_p00, r_p11, r_p22, r_p01, r_p12, r_p02;
    logic signed [PROD_W-1:0] r_pa11, r_pa22, r_pa12;
    logic signed [Q48_W-1:0]  r_q00, r_q11, r_q22, r_q01, r_q12, r_q02;
    logic signed [Q48_W-1:0]  r_qa11, r_qa22, r_qa12;
    logic signed [K_W-1:0]    r_sq_n, r_k1n, r_k2n, r_sq_d, r_k1d, r_k2d;
    logic signed [K_W-1:0]    r_sq_n2, r_sq_d2;
    logic [UA_W-1:0]          r_kmag [4];
    logic [3:0]               r_kneg;

    always_ff @(posedge i_clk) begin
        // raw Q56 products
        r_p00  <= PROD_W'(r_b0) * PROD_W'(r_b0);
        r_p11  <= PROD_W'(r_b1) * PROD_W'(r_b1);
        r_p22  <= PROD_W'(r_b2) * PROD_W'(r_b2);
        r_p01  <= PROD_W'(r_b0) * PROD_W'(r_b1);
        r_p12  <= PROD_W'(r_b1) * PROD_W'(r_b2);
        r_p02  <= PROD_W'(r_b0) * PROD_W'(r_b2);
        r_pa11 <= PROD_W'(r_a1) * PROD_W'(r_a1);
        r_pa22 <= PROD_W'(r_a2) * PROD_W'(r_a2);
        r_pa12 <= PROD_W'(r_a1) * PROD_W'(r_a2);
        // round to Q48
        r_q00  <= q48_round(r_p00);
        r_q11  <= q48_round(r_p11);
        r_q22  <= q48_round(r_p22);
        r_q01  <= q48_round(r_p01);
        r_q12  <= q48_round(r_p12);
        r_q02  <= q48_round(r_p02);
        r_qa11 <= q48_round(r_pa11);
        r_qa22 <= q48_round(r_pa22);
        r_qa12 <= q48_round(r_pa12);
        // combine into the constant and cosine-weighted terms
        r_sq_n <= K_W'(r_q00) + K_W'(r_q11) + K_W'(r_q22);
        r_k1n  <= K_W'(r_q01) + K_W'(r_q12);
        r_k2n  <= K_W'(r_q02);
        r_sq_d <= ONE_Q48 + K_W'(r_qa11) + K_W'(r_qa22);
        r_k1d  <= (K_W'(r_a1) <<< 20) + K_W'(r_qa12);
        r_k2d  <= K_W'(r_a2) <<< 20;
        // split into sign and magnitude for the cosine products
        r_sq_n2   <= r_sq_n;
        r_sq_d2   <= r_sq_d;
        r_kmag[0] <= k_mag(r_k1n);
        r_kmag[1] <= k_mag(r_k2n);
        r_kmag[2] <= k_mag(r_k1d);
        r_kmag[3] <= k_mag(r_k2d);
        r_kneg    <= {r_k2d[K_W-1], r_k1d[K_W-1], r_k2n[K_W-1], r_k1n[K_W-1]};
    end

    // ------------------------------------------------------- phase fold and angle
    logic [PHASE_BITS-1:0] w_p1;
    logic [PHASE_BITS-1:0] w_p2;
    logic                  w_fneg;
    logic [2:0]            r_fv;
    logic [P_W-1:0]        r_s1_p;
    logic                  r_s1_neg, r_s2_neg, r_s3_neg;
    logic [X_W-1:0]        r_s2_x;
    logic [X2_W-1:0]       r_s3_x2;

    // fold the phase into the first quarter wave
    always_comb begin
        w_p1   = (i_freq_phase > HALF) ? PHASE_BITS'(0) - i_freq_phase : i_freq_phase;
        w_fneg = (w_p1 > QUARTER);
        w_p2   = w_fneg ? HALF - w_p1 : w_p1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else begin
            r_fv <= {r_fv[1:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_p   <= P_W'(w_p2);
        r_s1_neg <= w_fneg;
        r_s2_x   <= X_W'((XP_W'(r_s1_p) * XP_W'(TWO_PI_Q30) + XP_W'(HALF)) >> PHASE_BITS);
        r_s2_neg <= r_s1_neg;
        r_s3_x2  <= X2_W'((63'(r_s2_x) * 63'(r_s2_x) + 63'(64'd1 << 29)) >> 30);
        r_s3_neg <= r_s2_neg;
    end

    // ------------------------------------------------------- Horner cell chain
    logic                w_tv   [TAYLOR_TERMS+1];
    logic [X2_W-1:0]     w_tx2  [TAYLOR_TERMS+1];
    logic [T_W-1:0]      w_tt   [TAYLOR_TERMS+1];
    logic                w_tneg [TAYLOR_TERMS+1];

    assign w_tv[0]   = r_fv[2];
    assign w_tx2[0]  = r_s3_x2;
    assign w_tt[0]   = ONE_Q30;
    assign w_tneg[0] = r_s3_neg;

    for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_taylor
        bqm_taylor_cell #(
            .HALF_DIV (TAYLOR_HALF[g])
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_tv[g]),
            .i_x2    (w_tx2[g]),
            .i_t     (w_tt[g]),
            .i_neg   (w_tneg[g]),
            .o_valid (w_tv[g+1]),
            .o_x2    (w_tx2[g+1]),
            .o_t     (w_tt[g+1]),
            .o_neg   (w_tneg[g+1])
        );
    end

    // --------------------------------------------- cos(w), cos(2w) as sign/magnitude
    logic [4:0]       r_pv;
    logic [T_W-1:0]   r_cmag [2];
    logic [1:0]       r_cneg;
    logic [X2_W-1:0]  w_csq;

    assign w_csq = X2_W'((62'(w_tt[TAYLOR_TERMS]) * 62'(w_tt[TAYLOR_TERMS])
                          + 62'(64'd1 << 28)) >> 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[3:0], w_tv[TAYLOR_TERMS]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmag[0] <= w_tt[TAYLOR_TERMS];
        r_cneg[0] <= w_tneg[TAYLOR_TERMS];
        if (w_csq >= X2_W'(ONE_Q30)) begin
            r_cmag[1] <= T_W'(w_csq - X2_W'(ONE_Q30));
            r_cneg[1] <= 1'b0;
        end else begin
            r_cmag[1] <= T_W'(X2_W'(ONE_Q30) - w_csq);
            r_cneg[1] <= 1'b1;
        end
    end

    // ------------------------------------------------- cosine-weighted products
    // lanes: b-cross with c1, b0*b2 with c2, a-cross with c1, a2 with c2
    logic [HI_W-1:0]          r_hi  [4];
    logic [LO_W-1:0]          r_lo  [4];
    logic [3:0]               r_sn;
    logic signed [SUM_W-1:0]  r_m   [4];
    logic [M_W-1:0]           w_mag [4];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_hi[i] <= HI_W'(HI_W'(r_kmag[i] >> 30) * HI_W'(r_cmag[i % 2]));
            r_lo[i] <= LO_W'(LO_W'(r_kmag[i][29:0]) * LO_W'(r_cmag[i % 2]));
            r_sn[i] <= r_kneg[i] ^ r_cneg[i % 2];
        end
    end

    // recombine the halves, rounding half away from zero
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_mag[i] = M_W'(r_hi[i]) + M_W'((r_lo[i] + LO_W'(64'd1 << 29)) >> 30);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_m[i] <= $signed(r_sn[i] ? SUM_W'(0) - SUM_W'(w_mag[i]) : SUM_W'(w_mag[i]));
        end
    end

    // ------------------------------------------------------- powers and flags
    logic signed [SUM_W-1:0] r_num, r_den;
    logic [DIV_W-1:0]        w_un, w_ud;
    logic                    w_dpole, w_nzero, w_ovf;
    t_res_flags              w_flags;
    logic [DIV_W-1:0]        r_d0_rem, r_d0_den;
    logic [DIV_LOW-1:0]      r_d0_bits;
    t_res_flags              r_d0_flags;

    always_ff @(posedge i_clk) begin
        r_num <= SUM_W'(r_sq_n2) + (r_m[0] <<< 1) + (r_m[1] <<< 1);
        r_den <= SUM_W'(r_sq_d2) + (r_m[2] <<< 1) + (r_m[3] <<< 1);
    end

    // classify: pole first, then non-positive numerator, then overflow
    always_comb begin
        w_un         = r_num[DIV_W-1:0];
        w_ud         = r_den[DIV_W-1:0];
        w_dpole      = r_den[SUM_W-1] || (r_den == '0);
        w_nzero      = r_num[SUM_W-1] || (r_num == '0);
        w_ovf        = ((w_un >> DIV_LOW) >= w_ud);
        w_flags.pole = w_dpole;
        w_flags.zero = !w_dpole && w_nzero;
        w_flags.sat  = w_dpole || (!w_nzero && w_ovf);
    end

    always_ff @(posedge i_clk) begin
        r_d0_rem   <= w_un >> DIV_LOW;
        r_d0_den   <= w_ud;
        r_d0_bits  <= w_un[DIV_LOW-1:0];
        r_d0_flags <= w_flags;
    end

    // ------------------------------------------------------- divider cell row
    logic               w_dv    [QUO_W+1];
    logic [DIV_W-1:0]   w_drem  [QUO_W+1];
    logic [DIV_W-1:0]   w_dden  [QUO_W+1];
    logic [DIV_LOW-1:0] w_dbits [QUO_W+1];
    logic [QUO_W-1:0]   w_dquo  [QUO_W+1];
    t_res_flags         w_dfl   [QUO_W+1];

    assign w_dv[0]    = r_pv[4];
    assign w_drem[0]  = r_d0_rem;
    assign w_dden[0]  = r_d0_den;
    assign w_dbits[0] = r_d0_bits;
    assign w_dquo[0]  = '0;
    assign w_dfl[0]   = r_d0_flags;

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        bqm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv[g]),
            .i_rem   (w_drem[g]),
            .i_den   (w_dden[g]),
            .i_bits  (w_dbits[g]),
            .i_quo   (w_dquo[g]),
            .i_flags (w_dfl[g]),
            .o_valid (w_dv[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_den   (w_dden[g+1]),
            .o_bits  (w_dbits[g+1]),
            .o_quo   (w_dquo[g+1]),
            .o_flags (w_dfl[g+1])
        );
    end

    // ------------------------------------------------------- square root cell row
    logic               w_sv    [ROOT_W+1];
    logic [REM_W-1:0]   w_srem  [ROOT_W+1];
    logic [ROOT_W-1:0]  w_sroot [ROOT_W+1];
    logic [QUO_W-1:0]   w_srad  [ROOT_W+1];
    t_res_flags         w_sfl   [ROOT_W+1];

    assign w_sv[0]    = w_dv[QUO_W];
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srad[0]  = w_dquo[QUO_W];
    assign w_sfl[0]   = w_dfl[QUO_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        bqm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sv[g]),
            .i_rem   (w_srem[g]),
            .i_root  (w_sroot[g]),
            .i_rad   (w_srad[g]),
            .i_flags (w_sfl[g]),
            .o_valid (w_sv[g+1]),
            .o_rem   (w_srem[g+1]),
            .o_root  (w_sroot[g+1]),
            .o_rad   (w_srad[g+1]),
            .o_flags (w_sfl[g+1])
        );
    end

    // ------------------------------------------------------- result register
    logic             r_ov;
    logic [MAG_W-1:0] r_mag;
    logic             r_sat;
    logic             r_pole;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= w_sv[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sfl[ROOT_W].sat) begin
            r_mag <= '1;
        end else if (w_sfl[ROOT_W].zero) begin
            r_mag <= '0;
        end else begin
            r_mag <= MAG_W'(w_sroot[ROOT_W]);
        end
        r_sat  <= w_sfl[ROOT_W].sat;
        r_pole <= w_sfl[ROOT_W].pole;
    end

    assign o_valid          = r_ov;
    assign o_magnitude      = r_mag;
    assign o_saturated      = r_sat;
    assign o_pole_on_circle = r_pole;

`ifndef NO_ASSERTIONS
    // every result traces back to a transaction a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without matching transaction");

    // a pole always reports a saturated, full-scale magnitude
    a_pole_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pole_on_circle) |-> (o_saturated && (o_magnitude == '1)))
        else $error("pole result not saturated");

    // a saturated result is full scale
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_magnitude == '1))
        else $error("saturated result below full scale");
`endif

endmodule
`default_nettype wire
